### hw/rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: shared constants for the backtracking choice stack
// Operation codes, payload widths and the "no choice" result value.
// ----------------------------------------------------------------------------
package bcs_pkg;

  // Payload widths fixed by the item format
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 8;
  localparam int CHOSEN_W = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_NEXT    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESET   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

  // Chosen value when no alternative is selected (-1)
  localparam logic [CHOSEN_W-1:0] CHOSEN_NONE = {CHOSEN_W{1'b1}};

  // Entry value above which advance stops popping
  localparam logic [COUNT_W-1:0] ENTRY_ONE = 8'd1;

endpackage

### hw/rtl/bcs_ram.sv
// ----------------------------------------------------------------------------
// bcs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/backtracking_choice_stack.sv
// Backtracking choice stack: depth-first enumerator of a choice tree.
// The result comes in the cycle after the item is taken for reset, for next
// with a zero count or a push, and for advance with no levels above position;
// next that replays a stored entry first passes the replay state (one stack memory read).
// Advance stays in the pop state while it pops levels, one memory read per level.
// Synchronous reset clears stack size, position and control; stack contents
// are left as they are. The result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// backtracking_choice_stack: top level
// Stack of remaining-alternative counts in one RAM, with a replay position.
// ----------------------------------------------------------------------------
module backtracking_choice_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [bcs_pkg::OP_W-1:0]           operation,
  input  logic [bcs_pkg::COUNT_W-1:0]        choice_count,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]   mark_position,
  output logic                               done,
  output logic signed [bcs_pkg::CHOSEN_W-1:0] chosen,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   position,
  output logic                               advanced,
  output logic                               error
);

  import bcs_pkg::*;

  localparam int PosW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam logic [PosW-1:0] DepthVal = PosW'(STACK_DEPTH);
  localparam logic [PosW-1:0] PosOne   = PosW'(1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REPLAY = 3'b010,
    S_POP    = 3'b100
  } state_t;

  state_t state, state_next;
  logic [PosW-1:0] stack_size, stack_size_next;
  logic [PosW-1:0] replay_pos, replay_pos_next;
  logic [COUNT_W-1:0] count_q;
  logic done_next, advanced_next, error_next;
  logic [CHOSEN_W-1:0] chosen_next;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;
  logic [PosW-1:0]    size_m1;
  logic               accept;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign size_m1 = stack_size - PosOne;
  assign position = replay_pos;

  bcs_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequence next, reset and advance items through the stack memory
  always_comb begin
    state_next      = state;
    stack_size_next = stack_size;
    replay_pos_next = replay_pos;
    done_next       = 1'b0;
    chosen_next     = CHOSEN_NONE;
    advanced_next   = 1'b0;
    error_next      = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = stack_size[AddrW-1:0];
    ram_wdata       = choice_count;
    ram_raddr       = size_m1[AddrW-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_NEXT: begin
              if (choice_count == '0) begin
                done_next = 1'b1;
              end else if (stack_size > replay_pos) begin
                // replay the stored entry at the position
                ram_raddr  = replay_pos[AddrW-1:0];
                state_next = S_REPLAY;
              end else if (stack_size >= DepthVal) begin
                done_next  = 1'b1;
                error_next = 1'b1;
              end else begin
                // push a new level; chosen is count minus itself
                ram_we          = 1'b1;
                stack_size_next = stack_size + PosOne;
                replay_pos_next = replay_pos + PosOne;
                chosen_next     = '0;
                done_next       = 1'b1;
              end
            end
            OP_RESET: begin
              done_next = 1'b1;
              if (mark_position > replay_pos) begin
                error_next = 1'b1;
              end else begin
                replay_pos_next = mark_position;
              end
            end
            OP_ADVANCE: begin
              if (stack_size > replay_pos) begin
                stack_size_next = size_m1;
                state_next      = S_POP;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_REPLAY: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (ram_rdata > count_q) begin
          error_next = 1'b1;
        end else begin
          replay_pos_next = replay_pos + PosOne;
          if (ram_rdata != '0) begin
            chosen_next = {1'b0, count_q - ram_rdata};
          end
        end
      end
      S_POP: begin
        if (ram_rdata > ENTRY_ONE) begin
          // decrement the level just read and keep it
          ram_we          = 1'b1;
          ram_wdata       = ram_rdata - ENTRY_ONE;
          stack_size_next = stack_size + PosOne;
          advanced_next   = 1'b1;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else if (stack_size > replay_pos) begin
          stack_size_next = size_m1;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stack_size <= '0;
      replay_pos <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      stack_size <= stack_size_next;
      replay_pos <= replay_pos_next;
      done       <= done_next;
    end
  end

  // Result and item payload registers
  always_ff @(posedge clk) begin
    chosen   <= chosen_next;
    advanced <= advanced_next;
    error    <= error_next;
    if (accept) begin
      count_q <= choice_count;
    end
  end

  // Position never passes the stack size
  a_pos_le_size: assert property (@(posedge clk) disable iff (rst)
    replay_pos <= stack_size)
    else $error("replay position above stack size");

  // Stack size never exceeds the depth
  a_size_le_depth: assert property (@(posedge clk) disable iff (rst)
    stack_size <= DepthVal)
    else $error("stack size above depth");

  // A result only follows an accepted item or a memory step
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> ($past(accept) || $past(state == S_REPLAY) || $past(state == S_POP)))
    else $error("result strobe without work");

  // A successful advance never reports an error and never changes position
  a_adv_clean: assert property (@(posedge clk) disable iff (rst)
    (done && advanced) |-> (!error && $stable(replay_pos)))
    else $error("advance result inconsistent");

endmodule
